### rtl/core/teleop_cursor_mapper_assert.svh
// assertion macros for the cursor mapper
`ifndef TELEOP_CURSOR_MAPPER_ASSERT_SVH
`define TELEOP_CURSOR_MAPPER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor mapper assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor mapper assertion failed");

`endif

### rtl/core/tcm_pkg.sv
// types, constants and the term program of the cursor mapper
package tcm_pkg;

  localparam int AccW = 56;
  localparam int AW = 36;
  localparam int BW = 17;
  localparam int TermW = 6;
  localparam logic [TermW-1:0] LastTerm = 6'd41;
  localparam logic [4:0] LastBit = 5'd16;
  localparam logic signed [BW-1:0] ShiftS = 17'sd11585;

  localparam logic [1:0] OpUpdCursor = 2'd0;
  localparam logic [1:0] OpUpdCamera = 2'd1;
  localparam logic [1:0] OpArmOnly = 2'd2;
  localparam logic [1:0] OpResetCursor = 2'd3;

  localparam logic [1:0] BtnNone = 2'd0;
  localparam logic [1:0] BtnGrab = 2'd1;
  localparam logic [1:0] BtnRelease = 2'd2;
  localparam logic [1:0] BtnKeep = 2'd3;

  localparam logic [1:0] RegScaleX = 2'd0;
  localparam logic [1:0] RegScaleY = 2'd1;
  localparam logic [1:0] RegScaleZ = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] arm_qw;
    logic signed [15:0] arm_qx;
    logic signed [15:0] arm_qy;
    logic signed [15:0] arm_qz;
    logic grab;
    logic signed [15:0] cam_qw;
    logic signed [15:0] cam_qx;
    logic [31:0] cam_qy_qz;
  } in_t;

  typedef struct packed {
    logic signed [31:0] cursor_x;
    logic signed [31:0] cursor_y;
    logic signed [31:0] cursor_z;
    logic signed [15:0] cur_qw;
    logic signed [15:0] cur_qx;
    logic signed [15:0] cur_qy;
    logic signed [15:0] cur_qz;
    logic [1:0] button_code;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
  } out_t;

  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_POST, ST_DONE} state_t;

  typedef enum logic [4:0] {
    A_DEL0, A_DEL1, A_DEL2, A_D0, A_D1, A_D2, A_T0, A_T1, A_T2,
    A_ARMW, A_ARMX, A_ARMY, A_ARMZ, A_TMPW, A_TMPX, A_TMPY, A_TMPZ
  } a_sel_t;

  typedef enum logic [3:0] {
    B_SC0, B_SC1, B_SC2, B_CW2, B_CW, B_CX, B_CY, B_CZ, B_S
  } b_sel_t;

  typedef enum logic [4:0] {
    DST_D0, DST_D1, DST_D2, DST_T0, DST_T1, DST_T2, DST_B0, DST_B1, DST_B2,
    DST_A0, DST_A1, DST_A2, DST_TMP0, DST_TMP1, DST_TMP2, DST_TMP3,
    DST_ORI0, DST_ORI1, DST_ORI2, DST_ORI3
  } dst_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic neg;
    logic last;
    dst_t dst;
  } term_t;

  function automatic term_t mk(a_sel_t a, b_sel_t b, logic neg, logic last, dst_t dst);
    term_t t;
    t.a = a;
    t.b = b;
    t.neg = neg;
    t.last = last;
    t.dst = dst;
    return t;
  endfunction

  // one signed product per term, summed until the last term of a result
  function automatic term_t term_rom(logic [TermW-1:0] idx);
    term_t t;
    t = mk(A_DEL0, B_SC0, 1'b0, 1'b1, DST_D0);
    case (idx)
      6'd0: t = mk(A_DEL0, B_SC0, 1'b0, 1'b1, DST_D0);
      6'd1: t = mk(A_DEL1, B_SC1, 1'b0, 1'b1, DST_D1);
      6'd2: t = mk(A_DEL2, B_SC2, 1'b0, 1'b1, DST_D2);
      6'd3: t = mk(A_D2, B_CY, 1'b0, 1'b0, DST_T0);
      6'd4: t = mk(A_D1, B_CZ, 1'b1, 1'b1, DST_T0);
      6'd5: t = mk(A_D0, B_CZ, 1'b0, 1'b0, DST_T1);
      6'd6: t = mk(A_D2, B_CX, 1'b1, 1'b1, DST_T1);
      6'd7: t = mk(A_D1, B_CX, 1'b0, 1'b0, DST_T2);
      6'd8: t = mk(A_D0, B_CY, 1'b1, 1'b1, DST_T2);
      6'd9: t = mk(A_T2, B_CY, 1'b0, 1'b0, DST_B0);
      6'd10: t = mk(A_T1, B_CZ, 1'b1, 1'b1, DST_B0);
      6'd11: t = mk(A_T0, B_CZ, 1'b0, 1'b0, DST_B1);
      6'd12: t = mk(A_T2, B_CX, 1'b1, 1'b1, DST_B1);
      6'd13: t = mk(A_T1, B_CX, 1'b0, 1'b0, DST_B2);
      6'd14: t = mk(A_T0, B_CY, 1'b1, 1'b1, DST_B2);
      6'd15: t = mk(A_T0, B_CW2, 1'b0, 1'b1, DST_A0);
      6'd16: t = mk(A_T1, B_CW2, 1'b0, 1'b1, DST_A1);
      6'd17: t = mk(A_T2, B_CW2, 1'b0, 1'b1, DST_A2);
      6'd18: t = mk(A_ARMY, B_S, 1'b0, 1'b0, DST_TMP0);
      6'd19: t = mk(A_ARMZ, B_S, 1'b1, 1'b1, DST_TMP0);
      6'd20: t = mk(A_ARMZ, B_S, 1'b1, 1'b0, DST_TMP1);
      6'd21: t = mk(A_ARMY, B_S, 1'b1, 1'b1, DST_TMP1);
      6'd22: t = mk(A_ARMW, B_S, 1'b1, 1'b0, DST_TMP2);
      6'd23: t = mk(A_ARMX, B_S, 1'b0, 1'b1, DST_TMP2);
      6'd24: t = mk(A_ARMW, B_S, 1'b0, 1'b0, DST_TMP3);
      6'd25: t = mk(A_ARMX, B_S, 1'b0, 1'b1, DST_TMP3);
      6'd26: t = mk(A_TMPW, B_CW, 1'b0, 1'b0, DST_ORI0);
      6'd27: t = mk(A_TMPX, B_CX, 1'b1, 1'b0, DST_ORI0);
      6'd28: t = mk(A_TMPY, B_CY, 1'b1, 1'b0, DST_ORI0);
      6'd29: t = mk(A_TMPZ, B_CZ, 1'b1, 1'b1, DST_ORI0);
      6'd30: t = mk(A_TMPX, B_CW, 1'b0, 1'b0, DST_ORI1);
      6'd31: t = mk(A_TMPW, B_CX, 1'b0, 1'b0, DST_ORI1);
      6'd32: t = mk(A_TMPZ, B_CY, 1'b0, 1'b0, DST_ORI1);
      6'd33: t = mk(A_TMPY, B_CZ, 1'b1, 1'b1, DST_ORI1);
      6'd34: t = mk(A_TMPY, B_CW, 1'b0, 1'b0, DST_ORI2);
      6'd35: t = mk(A_TMPW, B_CY, 1'b0, 1'b0, DST_ORI2);
      6'd36: t = mk(A_TMPX, B_CZ, 1'b0, 1'b0, DST_ORI2);
      6'd37: t = mk(A_TMPZ, B_CX, 1'b1, 1'b1, DST_ORI2);
      6'd38: t = mk(A_TMPZ, B_CW, 1'b0, 1'b0, DST_ORI3);
      6'd39: t = mk(A_TMPW, B_CZ, 1'b0, 1'b0, DST_ORI3);
      6'd40: t = mk(A_TMPY, B_CX, 1'b0, 1'b0, DST_ORI3);
      6'd41: t = mk(A_TMPX, B_CY, 1'b1, 1'b1, DST_ORI3);
      default: t = mk(A_DEL0, B_SC0, 1'b0, 1'b1, DST_D0);
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = 56'sd2147483647;
    lo = -56'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = 56'sd32767;
    lo = -56'sd32768;
    if (x > hi) return 16'sh7fff;
    if (x < lo) return 16'sh8000;
    return x[15:0];
  endfunction

endpackage

### rtl/core/teleop_cursor_mapper.sv
// cursor mapper top level: term sequencer around a bit-serial multiply-accumulate
// Update_cursor and update_camera run 42 signed product terms: each term is
// loaded, then its 17 multiplier bits are shifted through a single
// shift-and-add unit; each result is rounded in a post step, and the final
// result goes to the output register once the program ends. Arm_only and
// reset_cursor finish in the cycle they are taken and give no result. A new
// request is taken while a finished result still waits in the output register.
module teleop_cursor_mapper import tcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // architectural state
  logic [15:0] scale [3];
  logic signed [31:0] last_arm [3];
  logic signed [31:0] last_cursor [3];
  logic last_grab;

  // held request and intermediates
  in_t req;
  logic signed [31:0] dq [3];
  logic signed [AW-1:0] tq [3];
  logic signed [AW-1:0] bq [3];
  logic signed [31:0] np [3];
  logic signed [15:0] tmp [4];
  logic signed [15:0] ori [4];

  // sequencer and multiplier
  state_t state, state_next;
  logic [TermW-1:0] tcnt;
  logic [4:0] bcnt;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] mcand;
  logic [BW-1:0] mplier;

  term_t term;
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [AccW-1:0] addend;
  logic sub;
  logic is_d;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] shv;
  logic signed [AccW-1:0] npsum;
  logic [1:0] ai;
  logic in_acc;
  logic go;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  // a request that runs the term program
  assign go = in_acc && (in_data.operation == OpUpdCursor ||
                         in_data.operation == OpUpdCamera);
  assign out_free = !out_valid || !out_stall;
  assign term = term_rom(tcnt);

  // operand a: positions and quaternion terms, sign-extended
  always_comb begin
    case (term.a)
      A_DEL0: a_op = AW'(34'(req.pos_x) - 34'(last_arm[0]));
      A_DEL1: a_op = AW'(34'(req.pos_y) - 34'(last_arm[1]));
      A_DEL2: a_op = AW'(34'(req.pos_z) - 34'(last_arm[2]));
      A_D0: a_op = AW'(dq[0]);
      A_D1: a_op = AW'(dq[1]);
      A_D2: a_op = AW'(dq[2]);
      A_T0: a_op = tq[0];
      A_T1: a_op = tq[1];
      A_T2: a_op = tq[2];
      A_ARMW: a_op = AW'(req.arm_qw);
      A_ARMX: a_op = AW'(req.arm_qx);
      A_ARMY: a_op = AW'(req.arm_qy);
      A_ARMZ: a_op = AW'(req.arm_qz);
      A_TMPW: a_op = AW'(tmp[0]);
      A_TMPX: a_op = AW'(tmp[1]);
      A_TMPY: a_op = AW'(tmp[2]);
      A_TMPZ: a_op = AW'(tmp[3]);
      default: a_op = '0;
    endcase
  end

  // operand b: the narrow one, shifted out a bit per cycle
  always_comb begin
    case (term.b)
      B_SC0: b_op = $signed({1'b0, scale[0]});
      B_SC1: b_op = $signed({1'b0, scale[1]});
      B_SC2: b_op = $signed({1'b0, scale[2]});
      B_CW2: b_op = $signed({req.cam_qw, 1'b0});
      B_CW: b_op = BW'(req.cam_qw);
      B_CX: b_op = BW'(req.cam_qx);
      B_CY: b_op = BW'($signed(req.cam_qy_qz[31:16]));
      B_CZ: b_op = BW'($signed(req.cam_qy_qz[15:0]));
      B_S: b_op = ShiftS;
      default: b_op = '0;
    endcase
  end

  // top multiplier bit carries negative weight
  assign addend = mplier[0] ? mcand : '0;
  assign sub = term.neg ^ (bcnt == LastBit);

  // rounding half up, by 8 for the scaled delta and by 14 elsewhere
  assign is_d = (term.dst == DST_D0) || (term.dst == DST_D1) || (term.dst == DST_D2);
  assign rnd = acc + (is_d ? 56'sd128 : 56'sd8192);
  assign shv = is_d ? (rnd >>> 8) : (rnd >>> 14);

  always_comb begin
    case (term.dst)
      DST_A1: ai = 2'd1;
      DST_A2: ai = 2'd2;
      default: ai = 2'd0;
    endcase
  end
  assign npsum = AccW'(last_cursor[ai]) + AccW'(dq[ai]) + shv + (AccW'(bq[ai]) <<< 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.operation == OpUpdCursor ||
                       in_data.operation == OpUpdCamera)) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (bcnt == LastBit) state_next = term.last ? ST_POST : ST_LOAD;
      end
      ST_POST: state_next = (tcnt == LastTerm) ? ST_DONE : ST_LOAD;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      req <= in_data;
      tcnt <= '0;
      acc <= '0;
    end
    if (state == ST_LOAD) begin
      mcand <= AccW'(a_op);
      mplier <= b_op;
      bcnt <= '0;
    end
    if (state == ST_MUL) begin
      acc <= sub ? acc - addend : acc + addend;
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
      bcnt <= bcnt + 5'd1;
      if (bcnt == LastBit && !term.last) tcnt <= tcnt + 6'd1;
    end
    if (state == ST_POST) begin
      acc <= '0;
      if (tcnt != LastTerm) tcnt <= tcnt + 6'd1;
      unique case (term.dst)
        DST_D0: dq[0] <= sat32(shv);
        DST_D1: dq[1] <= sat32(shv);
        DST_D2: dq[2] <= sat32(shv);
        DST_T0: tq[0] <= shv[AW-1:0];
        DST_T1: tq[1] <= shv[AW-1:0];
        DST_T2: tq[2] <= shv[AW-1:0];
        DST_B0: bq[0] <= shv[AW-1:0];
        DST_B1: bq[1] <= shv[AW-1:0];
        DST_B2: bq[2] <= shv[AW-1:0];
        DST_A0, DST_A1, DST_A2: np[ai] <= sat32(npsum);
        DST_TMP0: tmp[0] <= sat16(shv);
        DST_TMP1: tmp[1] <= sat16(shv);
        DST_TMP2: tmp[2] <= sat16(shv);
        DST_TMP3: tmp[3] <= sat16(shv);
        DST_ORI0: ori[0] <= sat16(shv);
        DST_ORI1: ori[1] <= sat16(shv);
        DST_ORI2: ori[2] <= sat16(shv);
        DST_ORI3: ori[3] <= sat16(shv);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (state == ST_DONE && out_free) begin
      out_data.cursor_x <= (req.operation == OpUpdCursor) ? np[0] : last_cursor[0];
      out_data.cursor_y <= (req.operation == OpUpdCursor) ? np[1] : last_cursor[1];
      out_data.cursor_z <= (req.operation == OpUpdCursor) ? np[2] : last_cursor[2];
      out_data.cur_qw <= ori[0];
      out_data.cur_qx <= ori[1];
      out_data.cur_qy <= ori[2];
      out_data.cur_qz <= ori[3];
      if (req.operation != OpUpdCursor) out_data.button_code <= BtnNone;
      else if (req.grab && !last_grab) out_data.button_code <= BtnGrab;
      else if (!req.grab && last_grab) out_data.button_code <= BtnRelease;
      else if (req.grab) out_data.button_code <= BtnKeep;
      else out_data.button_code <= BtnNone;
      out_data.new_x <= np[0];
      out_data.new_y <= np[1];
      out_data.new_z <= np[2];
    end
  end

  // scales, stored arm and cursor, grab flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scale[0] <= 16'd256;
      scale[1] <= 16'd256;
      scale[2] <= 16'd256;
      for (int i = 0; i < 3; i++) begin
        last_arm[i] <= '0;
        last_cursor[i] <= '0;
      end
      last_grab <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegScaleX: scale[0] <= cfg_data;
          RegScaleY: scale[1] <= cfg_data;
          RegScaleZ: scale[2] <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_acc && in_data.operation == OpResetCursor) begin
        last_cursor[0] <= in_data.pos_x;
        last_cursor[1] <= in_data.pos_y;
        last_cursor[2] <= in_data.pos_z;
      end
      if (state == ST_IDLE && in_acc && in_data.operation == OpArmOnly) begin
        last_arm[0] <= in_data.pos_x;
        last_arm[1] <= in_data.pos_y;
        last_arm[2] <= in_data.pos_z;
        last_grab <= in_data.grab;
      end
      if (state == ST_DONE && out_free) begin
        last_arm[0] <= req.pos_x;
        last_arm[1] <= req.pos_y;
        last_arm[2] <= req.pos_z;
        last_grab <= req.grab;
        if (req.operation == OpUpdCursor) begin
          last_cursor[0] <= np[0];
          last_cursor[1] <= np[1];
          last_cursor[2] <= np[2];
        end
      end
    end
  end

`include "teleop_cursor_mapper_assert.svh"

  // multiplier never runs past its top bit
  `TCM_ASSERT_IMP(a_mul_bits, state == ST_MUL, bcnt <= LastBit)
  // result is only handed over once the whole program has run
  `TCM_ASSERT_IMP(a_done_term, state == ST_DONE, tcnt == LastTerm)
  // a computing request starts the program at its first term
  `TCM_ASSERT_NXT(a_start, go, state == ST_LOAD && tcnt == '0)

endmodule
